[rtl/mpfd_pkg.sv]
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared codes and default sizes for the page-organized mono frame store.
// ----------------------------------------------------------------------------
package mpfd_pkg;

   localparam int COLUMNS_DEF   = 128;
   localparam int ROWS_DEF      = 64;
   localparam int PIX_PER_PAGE  = 8;

   localparam logic [7:0] BYTE_ONES = 8'hff;

   localparam logic [1:0] CMD_POINT = 2'd0;
   localparam logic [1:0] CMD_LINE  = 2'd1;
   localparam logic [1:0] CMD_FILL  = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] PEN_ERASE  = 2'd0;
   localparam logic [1:0] PEN_SET    = 2'd1;
   localparam logic [1:0] PEN_INVERT = 2'd2;

endpackage

[rtl/mono_page_framebuffer_draw.sv]
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// Mono frame store of column-by-page bytes with point, line, fill and read.
// ----------------------------------------------------------------------------
//
//   channel  dir   handshake             fields
//   req_     in    req_valid/req_stall   cmd, x_a, y_a, x_b, y_b, pen
//   rsp_     out   rsp_valid/rsp_stall   read_byte (zero unless a read)
//
// One word in at a time; req_stall stays high until that word's result has
// been loaded into the output register. All work goes through one read port
// and one write port.
// Reset starts a clearing pass that zeroes all COLUMNS*PAGES bytes (1024 by default).
// Fill rewrites every byte. Lines step one column at a time (one row when
// vertical), stepping y per row crossed if sloped; plots read-modify-write.
// A stalled result holds in rsp_*; the next word can already start.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw #(
   parameter int COLUMNS = mpfd_pkg::COLUMNS_DEF,
   parameter int ROWS    = mpfd_pkg::ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_x_a,
   input  logic [7:0] req_y_a,
   input  logic [7:0] req_x_b,
   input  logic [7:0] req_y_b,
   input  logic [1:0] req_pen,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_byte
);
   import mpfd_pkg::*;

   localparam int PAGES       = (ROWS + PIX_PER_PAGE - 1) / PIX_PER_PAGE;
   localparam int STORE_BYTES = COLUMNS * PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CNT_W       = ADDR_W + 1;

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;  // post-reset zero sweep
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;  // wait on registered read
   localparam logic [2:0] S_FILL  = 3'd3;  // pipelined read k / write k-1
   localparam logic [2:0] S_PT    = 3'd4;  // plot: issue read
   localparam logic [2:0] S_WR    = 3'd5;  // plot: write modified byte
   localparam logic [2:0] S_ADJ   = 3'd6;  // bring remainder into [0,den)
   localparam logic [2:0] S_DONE  = 3'd7;  // hand result to output register

   // frame store
   logic [7:0]        mem [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              wr_en;

   // control
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;

   // line walker: cur steps columns (rows when vert), y/r track the floor
   logic [7:0]        cur_ff, cur_in;
   logic [7:0]        end_ff, end_in;
   logic [7:0]        y_ff, y_in;
   logic [7:0]        colv_ff, colv_in;
   logic              vert_ff, vert_in;
   logic signed [8:0] e_ff, e_in;
   logic [7:0]        den_ff, den_in;
   logic signed [10:0] r_ff, r_in;
   logic [1:0]        pen_ff, pen_in;
   logic [7:0]        res_ff, res_in;

   logic [7:0]  pcol, prow, pmask, xlo, xhi, ylo, yhi;
   logic        on_screen, rd_ok, x_up;
   logic [15:0] plot_wide, read_wide;
   logic signed [10:0] r_den;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign pcol      = vert_ff ? colv_ff : cur_ff;
   assign prow      = vert_ff ? cur_ff : y_ff;
   assign on_screen = ({1'b0, pcol} < 9'(COLUMNS)) && ({1'b0, prow} < 9'(ROWS));
   assign plot_wide = 16'(pcol) * 16'(PAGES) + 16'(prow[7:3]);
   assign pmask     = 8'b1 << prow[2:0];

   assign rd_ok     = ({1'b0, req_x_a} < 9'(COLUMNS)) && ({1'b0, req_y_a} < 9'(PAGES));
   assign read_wide = 16'(req_x_a) * 16'(PAGES) + 16'(req_y_a);

   assign x_up = req_x_b > req_x_a;
   assign xlo  = x_up ? req_x_a : req_x_b;
   assign xhi  = x_up ? req_x_b : req_x_a;
   assign ylo  = (req_y_b > req_y_a) ? req_y_a : req_y_b;
   assign yhi  = (req_y_b > req_y_a) ? req_y_b : req_y_a;

   assign r_den = $signed({3'b000, den_ff});

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      y_in         = y_ff;
      colv_in      = colv_ff;
      vert_in      = vert_ff;
      e_in         = e_ff;
      den_in       = den_ff;
      r_in         = r_ff;
      pen_in       = pen_ff;
      res_in       = res_ff;
      rd_addr      = '0;
      wr_addr      = '0;
      wr_data      = '0;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_byte_in  = rsp_byte_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[ADDR_W-1:0];
            if (k_ff == CNT_W'(STORE_BYTES - 1)) begin
               k_in     = '0;
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_IDLE: begin
            rd_addr = read_wide[ADDR_W-1:0];
            if (req_valid) begin
               pen_in  = req_pen;
               res_in  = '0;
               r_in    = '0;
               e_in    = '0;
               den_in  = 8'd1;
               vert_in = 1'b0;
               colv_in = req_x_a;
               y_in    = req_y_a;
               cur_in  = req_x_a;
               end_in  = req_x_a;
               case (req_cmd)
                  CMD_POINT: begin
                     state_in = S_PT;
                  end
                  CMD_LINE: begin
                     state_in = S_PT;
                     if (req_y_a == req_y_b) begin
                        cur_in = xlo;
                        end_in = xhi;
                     end else if (req_x_a == req_x_b) begin
                        vert_in = 1'b1;
                        cur_in  = ylo;
                        end_in  = yhi;
                     end else begin
                        cur_in = xlo;
                        end_in = xhi;
                        den_in = xhi - xlo;
                        if (x_up) begin
                           y_in = req_y_a;
                           e_in = $signed({1'b0, req_y_b}) - $signed({1'b0, req_y_a});
                        end else begin
                           y_in = req_y_b;
                           e_in = $signed({1'b0, req_y_a}) - $signed({1'b0, req_y_b});
                        end
                     end
                  end
                  CMD_FILL: begin
                     k_in     = '0;
                     state_in = S_FILL;
                  end
                  CMD_READ: begin
                     state_in = rd_ok ? S_READ : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            res_in   = rd_data_ff;
            state_in = S_DONE;
         end
         S_FILL: begin
            if (k_ff != CNT_W'(STORE_BYTES)) begin
               rd_addr = k_ff[ADDR_W-1:0];
            end
            if (k_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(k_ff - 1'b1);
               case (pen_ff)
                  PEN_SET:   wr_data = BYTE_ONES;
                  PEN_ERASE: wr_data = '0;
                  default:   wr_data = ~rd_data_ff;
               endcase
            end
            if (k_ff == CNT_W'(STORE_BYTES)) begin
               k_in     = '0;
               state_in = S_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_PT, S_WR: begin
            rd_addr = plot_wide[ADDR_W-1:0];
            if (state_ff == S_PT && on_screen) begin
               state_in = S_WR;
            end else begin
               if (state_ff == S_WR) begin
                  wr_en   = 1'b1;
                  wr_addr = plot_wide[ADDR_W-1:0];
                  case (pen_ff)
                     PEN_SET:    wr_data = rd_data_ff | pmask;
                     PEN_INVERT: wr_data = rd_data_ff ^ pmask;
                     default:    wr_data = rd_data_ff & ~pmask;
                  endcase
               end
               // step to next column / row
               if (cur_ff == end_ff) begin
                  state_in = S_DONE;
               end else begin
                  cur_in   = cur_ff + 1'b1;
                  r_in     = r_ff + {{2{e_ff[8]}}, e_ff};
                  state_in = S_ADJ;
               end
            end
         end
         S_ADJ: begin
            if (r_ff < 0) begin
               r_in = r_ff + r_den;
               y_in = y_ff - 1'b1;
            end else if (r_ff >= r_den) begin
               r_in = r_ff - r_den;
               y_in = y_ff + 1'b1;
            end else begin
               state_in = S_PT;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      y_ff        <= y_in;
      colv_ff     <= colv_in;
      vert_ff     <= vert_in;
      e_ff        <= e_in;
      den_ff      <= den_in;
      r_ff        <= r_in;
      pen_ff      <= pen_in;
      res_ff      <= res_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

endmodule

[rtl/mpfd_check.sv]
// ----------------------------------------------------------------------------
// mpfd_check
// Port-level checks on the frame store, bound to the top level.
// ----------------------------------------------------------------------------
module mpfd_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_byte
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte))
      else $error("stalled result changed");

   // clearing pass keeps input closed after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input open right after reset");

   // one word in flight: accept closes the input
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

   // a new result only comes out of a busy period
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result with no word in work");

endmodule

bind mono_page_framebuffer_draw mpfd_check u_mpfd_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_byte (rsp_read_byte)
);
